// ===== rtl/pps_disciplined_event_timestamper_macros.svh =====
// Assertion macros used by the timestamper back end (pdet_exec)
`ifndef PPS_DISCIPLINED_EVENT_TIMESTAMPER_MACROS_SVH
`define PPS_DISCIPLINED_EVENT_TIMESTAMPER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define PDET_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset
`define PDET_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pdet_pkg.sv =====
// Types, codes and constants of the event timestamper
`default_nettype none

package pdet_pkg;

    typedef enum logic [2:0] {
        K_TICK  = 3'd0,
        K_PPS   = 3'd1,
        K_EVENT = 3'd2,
        K_DATE  = 3'd3,
        K_POP   = 3'd4,
        K_NOP   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DROP   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_UNSYNC = 2'd3
    } t_status;

    typedef struct packed {
        t_kind       kind;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_cmd;

    localparam logic [19:0] TPS_RESET  = 20'd1000;
    localparam logic [31:0] TICK_MAX   = 32'hFFFF_FFFF;
    localparam logic [12:0] EPOCH_YEAR = 13'd1970;
    // leap years in 0 .. 1969
    localparam logic [22:0] LEAPS_EPOCH = 23'd478;

    function automatic t_kind classify(input logic [2:0] opcode);
        t_kind k;
        case (opcode)
            3'd0:    k = K_TICK;
            3'd1:    k = K_PPS;
            3'd2:    k = K_EVENT;
            3'd3:    k = K_DATE;
            3'd4:    k = K_POP;
            default: k = K_NOP;
        endcase
        return k;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pdet_ram.sv =====
// Generic single-port-write, registered-read RAM
`default_nettype none

module pdet_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/pdet_front.sv =====
// Front end: accepts items, decodes the opcode, two-entry command queue
`default_nettype none

module pdet_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [2:0]     i_opcode,
    input  wire logic [11:0]    i_year,
    input  wire logic [3:0]     i_month,
    input  wire logic [4:0]     i_day,
    input  wire logic [4:0]     i_hour,
    input  wire logic [5:0]     i_minute,
    input  wire logic [5:0]     i_second,
    output pdet_pkg::t_cmd      o_cmd,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_take
);

    pdet_pkg::t_cmd r_slot [2];
    logic           r_head;
    logic [1:0]     r_cnt;

    logic           do_push;
    logic           do_take;
    logic           tail;
    pdet_pkg::t_cmd n_cmd;

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_slot[r_head];
    assign do_push     = push && !full;
    assign do_take     = i_cmd_take && o_cmd_valid;
    assign tail        = r_head ^ r_cnt[0];

    always_comb begin
        n_cmd.kind   = pdet_pkg::classify(i_opcode);
        n_cmd.year   = i_year;
        n_cmd.month  = i_month;
        n_cmd.day    = i_day;
        n_cmd.hour   = i_hour;
        n_cmd.minute = i_minute;
        n_cmd.second = i_second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_take) begin
                r_head <= ~r_head;
            end
            case ({do_push, do_take})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[tail] <= n_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pdet_exec.sv =====
// Back end: time base, tick counter, stamp queue and date conversion
`default_nettype none

`include "pps_disciplined_event_timestamper_macros.svh"

module pdet_exec #(
    parameter int QUEUE_SLOTS = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  pdet_pkg::t_cmd      i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_take,
    input  wire logic [19:0]    i_tps,
    input  wire logic           i_pop,
    output logic                o_out_valid,
    output logic [1:0]          o_status,
    output logic [63:0]         o_stamp,
    output logic [2:0]          o_queue_count
);

    localparam int AW = $clog2(QUEUE_SLOTS);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_SLOTS - 1);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_DAYS = 8'b0000_1000,
        S_SECS = 8'b0001_0000,
        S_MLO  = 8'b0010_0000,
        S_MHI  = 8'b0100_0000,
        S_SUM  = 8'b1000_0000
    } t_state;

    t_state         r_state;
    logic [31:0]    r_tick;
    logic [63:0]    r_pend;
    logic [63:0]    r_cur;
    logic [AW-1:0]  r_rd;
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_count;
    logic           r_out_valid;
    logic [1:0]     r_status;
    logic [63:0]    r_stamp;
    logic [2:0]     r_qcnt;
    pdet_pkg::t_cmd r_cmd;
    logic [5:0]     r_qa;
    logic [5:0]     r_qb;
    logic [5:0]     r_qy;
    logic [22:0]    r_days;
    logic [40:0]    r_secs;
    logic [40:0]    r_plo;
    logic signed [40:0] r_phi;

    logic           out_free;
    logic           take;
    logic           event_ok;
    logic           pop_ok;
    logic           load_out;
    logic [1:0]     n_status;
    logic [63:0]    n_stamp;
    logic [2:0]     n_qcnt;
    logic [63:0]    ram_rdata;
    logic [63:0]    ev_stamp;
    logic [12:0]    yr;
    logic [12:0]    yoff;
    logic [3:0]     mon;
    logic           leap;
    logic [22:0]    n_days;
    logic [40:0]    n_secs;
    logic [40:0]    n_plo;
    logic signed [40:0] n_phi;
    logic [63:0]    n_sum;
    logic [AW:0]    span_raw;

    function automatic logic [5:0] div100(input logic [12:0] x);
        logic [25:0] p;
        p = 26'(x) * 26'd5243;
        return p[24:19];
    endfunction

    function automatic logic [AW-1:0] step(input logic [AW-1:0] p);
        return (p == LAST) ? '0 : p + 1'b1;
    endfunction

    assign out_free   = !r_out_valid || i_pop;
    assign take       = (r_state == S_IDLE) && i_cmd_valid && out_free;
    assign o_cmd_take = take;
    assign event_ok   = (i_cmd.kind == pdet_pkg::K_EVENT) && (r_cur != 64'd0)
                        && (r_count != LAST);
    assign pop_ok     = (i_cmd.kind == pdet_pkg::K_POP) && (r_count != '0);
    assign load_out   = (take && (i_cmd.kind != pdet_pkg::K_DATE) && !pop_ok)
                        || (((r_state == S_READ) || (r_state == S_SUM)) && out_free);
    assign ev_stamp   = r_cur + 64'(r_tick);

    pdet_ram #(
        .WIDTH (64),
        .DEPTH (QUEUE_SLOTS)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (take && event_ok),
        .i_waddr (r_wr),
        .i_wdata (ev_stamp),
        .i_re    (take && pop_ok),
        .i_raddr (r_rd),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_status = pdet_pkg::ST_OK;
        n_stamp  = 64'd0;
        n_qcnt   = 3'(r_count);
        if (r_state == S_READ) begin
            n_stamp = ram_rdata;
        end else if (r_state == S_IDLE) begin
            case (i_cmd.kind)
                pdet_pkg::K_PPS: begin
                    if (r_pend == 64'd0) n_status = pdet_pkg::ST_UNSYNC;
                end
                pdet_pkg::K_EVENT: begin
                    if (r_cur == 64'd0) begin
                        n_status = pdet_pkg::ST_UNSYNC;
                    end else if (r_count == LAST) begin
                        n_status = pdet_pkg::ST_DROP;
                    end else begin
                        n_qcnt = 3'(r_count + 1'b1);
                    end
                end
                pdet_pkg::K_POP: begin
                    if (r_count == '0) n_status = pdet_pkg::ST_EMPTY;
                end
                default: begin
                end
            endcase
        end
    end

    // date conversion datapath
    always_comb begin
        yr   = {1'b0, r_cmd.year};
        yoff = yr - pdet_pkg::EPOCH_YEAR;
        if (r_cmd.month == 4'd0) begin
            mon = 4'd1;
        end else if (r_cmd.month > 4'd12) begin
            mon = 4'd12;
        end else begin
            mon = r_cmd.month;
        end
        leap = (yr[1:0] == 2'b00)
               && ((13'(13'(r_qy) * 13'd100) != yr) || (r_qy[1:0] == 2'b00));
        n_days = {{10{yoff[12]}}, yoff} * 23'd365
                 + 23'((yr + 13'd3) >> 2) - 23'(r_qa) + 23'(r_qb)
                 - pdet_pkg::LEAPS_EPOCH
                 + 23'(pdet_pkg::days_before_month(mon))
                 + 23'((mon > 4'd2) && leap)
                 + 23'(r_cmd.day) - 23'd1;
        n_secs = {{18{r_days[22]}}, r_days} * 41'd86400
                 + 41'(r_cmd.hour) * 41'd3600
                 + 41'(r_cmd.minute) * 41'd60
                 + 41'(r_cmd.second);
        n_plo = {20'd0, r_secs[20:0]} * {21'd0, i_tps};
        n_phi = $signed(r_secs[40:21]) * $signed({1'b0, i_tps});
        n_sum = {23'd0, r_plo} + {{2{r_phi[40]}}, r_phi, 21'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= 32'd0;
            r_pend      <= 64'd0;
            r_cur       <= 64'd0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        case (i_cmd.kind)
                            pdet_pkg::K_TICK: begin
                                if (r_tick != pdet_pkg::TICK_MAX) r_tick <= r_tick + 32'd1;
                            end
                            pdet_pkg::K_PPS: begin
                                if (r_pend != 64'd0) begin
                                    r_tick <= 32'd0;
                                    r_cur  <= r_pend;
                                end
                            end
                            pdet_pkg::K_EVENT: begin
                                if (event_ok) begin
                                    r_wr    <= step(r_wr);
                                    r_count <= r_count + 1'b1;
                                end
                            end
                            pdet_pkg::K_DATE: r_state <= S_DIV;
                            pdet_pkg::K_POP: begin
                                if (pop_ok) begin
                                    r_rd    <= step(r_rd);
                                    r_count <= r_count - 1'b1;
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_READ: begin
                    if (out_free) r_state <= S_IDLE;
                end
                S_DIV:  r_state <= S_DAYS;
                S_DAYS: r_state <= S_SECS;
                S_SECS: r_state <= S_MLO;
                S_MLO:  r_state <= S_MHI;
                S_MHI:  r_state <= S_SUM;
                S_SUM: begin
                    if (out_free) begin
                        r_pend  <= n_sum;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status <= n_status;
            r_stamp  <= n_stamp;
            r_qcnt   <= n_qcnt;
        end
        if (take) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_DIV) begin
            r_qa <= div100(yr + 13'd99);
            r_qb <= div100(13'((yr + 13'd399) >> 2));
            r_qy <= div100(yr);
        end
        if (r_state == S_DAYS) r_days <= n_days;
        if (r_state == S_SECS) r_secs <= n_secs;
        if (r_state == S_MLO)  r_plo  <= n_plo;
        if (r_state == S_MHI)  r_phi  <= n_phi;
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_stamp       = r_stamp;
    assign o_queue_count = r_qcnt;

    // occupancy as seen from the two pointers
    assign span_raw = {1'b0, r_wr} + (AW+1)'(QUEUE_SLOTS) - {1'b0, r_rd};

    `PDET_ASSERT_IMP(a_count_bound, 1'b1, r_count <= LAST, "stamp queue over its usable depth")
    `PDET_ASSERT_IMP(a_count_ptrs, 1'b1, r_count == ((span_raw >= (AW+1)'(QUEUE_SLOTS)) ? AW'(span_raw - (AW+1)'(QUEUE_SLOTS)) : AW'(span_raw)), "queue count disagrees with pointers")
    `PDET_ASSERT_NXT(a_out_hold, r_out_valid && !i_pop, r_out_valid, "result lost before transfer")

endmodule

`default_nettype wire

// ===== rtl/pps_disciplined_event_timestamper.sv =====
// PPS-disciplined event timestamper: top level
//
// Input queue: drive push with an item when full is low; opcode 0 tick,
// 1 PPS edge, 2 external event, 3 date load (UTC fields), 4 pop stamp.
// Result queue: while empty is low a result (status, stamp, queue_count)
// is on the outputs; pop takes it. Every item gives exactly one result.
// Config channel: i_cfg_valid with o_cfg_ready writes ticks per second;
// write it only while the block is idle.
// With the back end free, the result is registered as the item is taken
// from the command queue; a pop first does a registered stamp RAM read.
// Throughput: one item per cycle for tick, PPS, event and unused codes while
// each result is popped; a pop or a date load (division, day, second and split
// 41x20 multiply steps) holds the back end until its result is loaded.
// A two-entry command queue keeps accepting while the back end works.
// When the receiver stalls the result register holds and the back end
// waits; the input side fills and full rises.
// Reset (synchronous, active low): empty queues, base times and tick
// counter cleared, ticks per second back to 1000.
`default_nettype none

module pps_disciplined_event_timestamper #(
    parameter int QUEUE_SLOTS = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [2:0]     i_opcode,
    input  wire logic [11:0]    i_year,
    input  wire logic [3:0]     i_month,
    input  wire logic [4:0]     i_day,
    input  wire logic [4:0]     i_hour,
    input  wire logic [5:0]     i_minute,
    input  wire logic [5:0]     i_second,
    output logic                empty,
    input  wire logic           pop,
    output logic [1:0]          o_status,
    output logic [63:0]         o_stamp,
    output logic [2:0]          o_queue_count,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [19:0]    i_cfg_data
);

    logic [19:0]    r_tps;
    pdet_pkg::t_cmd cmd;
    logic           cmd_valid;
    logic           cmd_take;
    logic           out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= pdet_pkg::TPS_RESET;
        end else if (i_cfg_valid) begin
            r_tps <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign empty       = !out_valid;

    pdet_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_opcode    (i_opcode),
        .i_year      (i_year),
        .i_month     (i_month),
        .i_day       (i_day),
        .i_hour      (i_hour),
        .i_minute    (i_minute),
        .i_second    (i_second),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take)
    );

    pdet_exec #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_exec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_take    (cmd_take),
        .i_tps         (r_tps),
        .i_pop         (pop && out_valid),
        .o_out_valid   (out_valid),
        .o_status      (o_status),
        .o_stamp       (o_stamp),
        .o_queue_count (o_queue_count)
    );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the PPS-disciplined event timestamper
`timescale 1ns / 100ps

localparam int          STAMP_SLOTS  = 8;
localparam logic [63:0] UNIX_EPOCH   = 64'd1970;
localparam logic [63:0] SECS_PER_DAY = 64'd86400;
localparam logic [2:0]  OPC_TOP      = 3'd7;
localparam logic [8:0]  MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
};

typedef struct packed {
    logic [2:0]  opcode;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
} t_stamp_cmd;

typedef struct packed {
    pdet_pkg::t_status status;
    logic [63:0]       stamp;
    logic [2:0]        count;
} t_stamp_result;

class stamp_scoreboard;
    logic [19:0]   tps;
    logic [31:0]   tick_count;
    logic [63:0]   pending_base;
    logic [63:0]   current_base;
    logic [63:0]   slot_store [STAMP_SLOTS];
    int unsigned   rd_slot;
    int unsigned   wr_slot;
    t_stamp_result awaited [$];
    int            errors;

    function new();
        tps          = pdet_pkg::TPS_RESET;
        tick_count   = '0;
        pending_base = '0;
        current_base = '0;
        rd_slot      = 0;
        wr_slot      = 0;
        errors       = 0;
    endfunction

    function void set_tps(logic [19:0] value);
        tps = value;
    endfunction

    function int outstanding();
        return awaited.size();
    endfunction

    // leap years in 0 .. y-1
    function logic [63:0] leaps_before(logic [63:0] y);
        return (y + 64'd3) / 64'd4 - (y + 64'd99) / 64'd100 + (y + 64'd399) / 64'd400;
    endfunction

    function logic [63:0] utc_to_ticks(t_stamp_cmd c);
        logic [63:0] y;
        logic [63:0] m;
        logic [63:0] days;
        logic [63:0] secs;
        bit          leap;
        y = 64'(c.year);
        m = 64'(c.month);
        if (m < 64'd1) m = 64'd1;
        if (m > 64'd12) m = 64'd12;
        leap = (y % 64'd4 == 0 && y % 64'd100 != 0) || y % 64'd400 == 0;
        days = (y - UNIX_EPOCH) * 64'd365 + leaps_before(y) - leaps_before(UNIX_EPOCH);
        days = days + 64'(MONTH_START[m - 64'd1]);
        if (m > 64'd2 && leap) days = days + 64'd1;
        days = days + 64'(c.day) - 64'd1;
        secs = days * SECS_PER_DAY + 64'(c.hour) * 64'd3600
             + 64'(c.minute) * 64'd60 + 64'(c.second);
        return secs * 64'(tps);
    endfunction

    function void note_item(t_stamp_cmd c);
        t_stamp_result r;
        int unsigned   nxt;
        r.status = pdet_pkg::ST_OK;
        r.stamp  = '0;
        case (c.opcode)
            pdet_pkg::K_TICK: begin
                if (tick_count != '1) tick_count++;
            end
            pdet_pkg::K_PPS: begin
                if (pending_base != '0) begin
                    tick_count   = '0;
                    current_base = pending_base;
                end else begin
                    r.status = pdet_pkg::ST_UNSYNC;
                end
            end
            pdet_pkg::K_EVENT: begin
                if (current_base == '0) begin
                    r.status = pdet_pkg::ST_UNSYNC;
                end else begin
                    nxt = (wr_slot + 1) % STAMP_SLOTS;
                    if (nxt == rd_slot) begin
                        r.status = pdet_pkg::ST_DROP;
                    end else begin
                        slot_store[wr_slot] = current_base + 64'(tick_count);
                        wr_slot = nxt;
                    end
                end
            end
            pdet_pkg::K_DATE: begin
                pending_base = utc_to_ticks(c);
            end
            pdet_pkg::K_POP: begin
                if (rd_slot == wr_slot) begin
                    r.status = pdet_pkg::ST_EMPTY;
                end else begin
                    r.stamp = slot_store[rd_slot];
                    rd_slot = (rd_slot + 1) % STAMP_SLOTS;
                end
            end
            default: begin
            end
        endcase
        r.count = 3'((wr_slot + STAMP_SLOTS - rd_slot) % STAMP_SLOTS);
        awaited.push_back(r);
    endfunction

    task report(string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        errors++;
    endtask

    task check_result(logic [1:0] got_status, logic [63:0] got_stamp, logic [2:0] got_count);
        t_stamp_result e;
        if (awaited.size() == 0) begin
            report("result transfer with nothing awaited");
            return;
        end
        e = awaited.pop_front();
        if (got_status !== e.status)
            report($sformatf("status %0d, want %0d", got_status, e.status));
        if (got_stamp !== e.stamp)
            report($sformatf("stamp %h, want %h", got_stamp, e.stamp));
        if (got_count !== e.count)
            report($sformatf("queue_count %0d, want %0d", got_count, e.count));
    endtask
endclass

module testbench;
    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [2:0]  i_opcode;
    logic [11:0] i_year;
    logic [3:0]  i_month;
    logic [4:0]  i_day;
    logic [4:0]  i_hour;
    logic [5:0]  i_minute;
    logic [5:0]  i_second;
    logic        empty;
    logic        pop;
    logic [1:0]  o_status;
    logic [63:0] o_stamp;
    logic [2:0]  o_queue_count;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [19:0] i_cfg_data;

    int send_idle_pct;
    int recv_stall_pct;

    stamp_scoreboard stamps = new();

    pps_disciplined_event_timestamper #(
        .QUEUE_SLOTS(STAMP_SLOTS)
    ) u_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: check on transfer, then pick next pop
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty)
                stamps.check_result(o_status, o_stamp, o_queue_count);
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic t_stamp_cmd any_cmd(logic [2:0] opc);
        t_stamp_cmd c;
        c.opcode = opc;
        c.year   = 12'($urandom);
        c.month  = 4'($urandom);
        c.day    = 5'($urandom);
        c.hour   = 5'($urandom);
        c.minute = 6'($urandom);
        c.second = 6'($urandom);
        return c;
    endfunction

    function automatic t_stamp_cmd date_cmd(int yr, int mo, int dy, int hr, int mi, int se);
        t_stamp_cmd c;
        c.opcode = pdet_pkg::K_DATE;
        c.year   = 12'(yr);
        c.month  = 4'(mo);
        c.day    = 5'(dy);
        c.hour   = 5'(hr);
        c.minute = 6'(mi);
        c.second = 6'(se);
        return c;
    endfunction

    function automatic t_stamp_cmd random_date();
        if ($urandom_range(4) == 0)
            return any_cmd(pdet_pkg::K_DATE);
        return date_cmd($urandom_range(2099, 1970), $urandom_range(12, 1),
                        $urandom_range(31, 1), $urandom_range(23), $urandom_range(59),
                        $urandom_range(59));
    endfunction

    task send_cmd(input t_stamp_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push     <= 1'b1;
        i_opcode <= c.opcode;
        i_year   <= c.year;
        i_month  <= c.month;
        i_day    <= c.day;
        i_hour   <= c.hour;
        i_minute <= c.minute;
        i_second <= c.second;
        do @(posedge i_clk); while (full);
        stamps.note_item(c);
    endtask

    task send_op(input logic [2:0] opc);
        send_cmd(any_cmd(opc));
    endtask

    task drain();
        push <= 1'b0;
        while (stamps.outstanding() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task write_tps(input logic [19:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        stamps.set_tps(value);
    endtask

    // mixes resync sequences, opcode noise and event/pop bursts
    task run_random(input int n);
        int sent;
        int burst;
        int ev_pct;
        int r;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 15) begin
                send_cmd(random_date());
                burst = $urandom_range(3);
                repeat (burst) send_op(pdet_pkg::K_TICK);
                send_op(pdet_pkg::K_PPS);
                sent += burst + 2;
            end else if (r < 25) begin
                burst = $urandom_range(4, 1);
                repeat (burst) send_op(3'($urandom_range(OPC_TOP)));
                sent += burst;
            end else begin
                burst  = $urandom_range(20, 5);
                ev_pct = $urandom_range(50, 10);
                repeat (burst) begin
                    r = $urandom_range(99);
                    if (r < 35)
                        send_op(pdet_pkg::K_TICK);
                    else if (r < 35 + ev_pct)
                        send_op(pdet_pkg::K_EVENT);
                    else if (r < 95)
                        send_op(pdet_pkg::K_POP);
                    else
                        send_op(pdet_pkg::K_PPS);
                end
                sent += burst;
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        i_opcode    <= '0;
        i_year      <= '0;
        i_month     <= '0;
        i_day       <= '0;
        i_hour      <= '0;
        i_minute    <= '0;
        i_second    <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unsynchronised start, empty pop, epoch date gives zero base
        send_op(pdet_pkg::K_EVENT);
        send_op(pdet_pkg::K_PPS);
        send_op(pdet_pkg::K_POP);
        send_op(pdet_pkg::K_TICK);
        send_cmd(date_cmd(1970, 1, 1, 0, 0, 0));
        send_op(pdet_pkg::K_PPS);
        // leap day either side of end of February
        send_cmd(date_cmd(2000, 2, 29, 23, 59, 59));
        send_op(pdet_pkg::K_PPS);
        send_op(pdet_pkg::K_TICK);
        send_op(pdet_pkg::K_EVENT);
        send_cmd(date_cmd(2000, 3, 1, 0, 0, 0));
        send_op(pdet_pkg::K_PPS);
        send_op(pdet_pkg::K_EVENT);
        // field extremes, month clamp, day zero, pre-epoch year
        send_cmd(date_cmd(4095, 15, 31, 31, 63, 63));
        send_op(pdet_pkg::K_PPS);
        send_op(pdet_pkg::K_EVENT);
        send_cmd(date_cmd(0, 0, 0, 0, 0, 0));
        send_op(pdet_pkg::K_PPS);
        send_op(pdet_pkg::K_EVENT);
        send_op(pdet_pkg::K_POP);
        for (int k = pdet_pkg::K_NOP; k <= OPC_TOP; k++) send_op(3'(k));
        // fill until an event is dropped
        repeat (5) send_op(pdet_pkg::K_EVENT);
        run_random(64);
        drain();

        write_tps(20'd1);
        send_idle_pct = 84;
        repeat (7) send_op(pdet_pkg::K_POP);
        // base of all ones, stamp wraps to zero one tick later
        send_cmd(date_cmd(1969, 12, 31, 23, 59, 59));
        send_op(pdet_pkg::K_PPS);
        send_op(pdet_pkg::K_EVENT);
        send_op(pdet_pkg::K_TICK);
        send_op(pdet_pkg::K_EVENT);
        repeat (2) send_op(pdet_pkg::K_POP);
        run_random(64);
        drain();

        write_tps(20'd1000000);
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        run_random(64);
        drain();

        write_tps('0);
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        run_random(64);
        drain();

        write_tps('1);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(64);
        drain();

        write_tps(20'($urandom_range(1000000, 1)));
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        run_random(64);
        drain();

        if (stamps.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
